@@ hdl/mbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbp_pkg: shared types and constants of the MSB-first bit packer
// Holds the job format that travels from the front end to the byte emitter.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int unsigned ValueBits  = 32;  // width of data_value
  localparam int unsigned CountBits  = 6;   // width of bit_count
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned VbBits     = 4;   // width of valid_bits
  localparam int unsigned NbBits     = 3;   // byte count of one job, 0..4
  localparam int unsigned QueueDepth = 2;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // One unit of work for the back end: bytes are taken from word, most
  // significant of the nbytes low bytes first.
  typedef struct packed {
    logic [ValueBits-1:0] word;
    logic [NbBits-1:0]    nbytes;
    logic [VbBits-1:0]    valid_bits;
  } job_t;

endpackage

@@ hdl/mbp_front.sv @@
// ----------------------------------------------------------------------------
// mbp_front: request intake and bit accumulation
// Holds the pending partial byte, merges appended code bits into it and turns
// each request into a job of whole bytes (or one partial byte on a flush).
// ----------------------------------------------------------------------------
module mbp_front #(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  input  logic                            req_kind,
  input  logic [mbp_pkg::ValueBits-1:0]   req_value,
  input  logic [mbp_pkg::CountBits-1:0]   req_count,
  input  logic                            q_full,
  output logic                            req_ready,
  output logic                            push,
  output mbp_pkg::job_t                   push_job
);

  localparam int unsigned LimitInt = (MAX_CODE_BITS < mbp_pkg::ValueBits) ?
                                     MAX_CODE_BITS : mbp_pkg::ValueBits;
  localparam logic [mbp_pkg::CountBits-1:0] Limit = LimitInt[mbp_pkg::CountBits-1:0];
  localparam int unsigned AccBits = mbp_pkg::ValueBits + mbp_pkg::ByteBits;

  logic [7:0]                        pending_r, pending_nxt;
  logic [3:0]                        free_r, free_nxt;
  logic [3:0]                        filled;
  logic [mbp_pkg::CountBits-1:0]     cnt;
  logic [mbp_pkg::ValueBits-1:0]     val_masked;
  logic [7:0]                        head;
  logic [AccBits-1:0]                acc;
  logic [mbp_pkg::CountBits-1:0]     nbits;
  logic [2:0]                        rem;
  logic [mbp_pkg::NbBits-1:0]        nb;
  logic                              has_result;
  logic                              accept;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;

  always_comb begin
    filled     = 4'd8 - free_r;
    cnt        = (req_count > Limit) ? Limit : req_count;
    val_masked = req_value & ~({mbp_pkg::ValueBits{1'b1}} << cnt);
    head       = pending_r >> free_r;
    acc        = ({{mbp_pkg::ValueBits{1'b0}}, head} << cnt) |
                 {{mbp_pkg::ByteBits{1'b0}}, val_masked};
    nbits      = mbp_pkg::CountBits'(filled) + cnt;
    rem        = nbits[2:0];
    nb         = nbits[mbp_pkg::CountBits-1:3];
    pending_nxt = 8'(acc[7:0] << (4'd8 - {1'b0, rem}));
    free_nxt    = 4'd8 - {1'b0, rem};

    if (req_kind == mbp_pkg::KIND_FLUSH) begin
      has_result          = (free_r != 4'd8);
      push_job.word       = {{(mbp_pkg::ValueBits-8){1'b0}}, pending_r};
      push_job.nbytes     = mbp_pkg::NbBits'(1);
      push_job.valid_bits = filled;
    end else begin
      has_result          = (cnt != '0) && (nb != '0);
      push_job.word       = mbp_pkg::ValueBits'(acc >> rem);
      push_job.nbytes     = nb;
      push_job.valid_bits = 4'd8;
    end
    push = accept && has_result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
      free_r    <= 4'd8;
    end else if (accept && req_kind == mbp_pkg::KIND_APPEND && cnt != '0) begin
      pending_r <= pending_nxt;
      free_r    <= free_nxt;
    end
  end

endmodule

@@ hdl/mbp_queue.sv @@
// ----------------------------------------------------------------------------
// mbp_queue: short job queue
// A small FIFO that decouples request intake from byte emission.
// ----------------------------------------------------------------------------
module mbp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbp_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output mbp_pkg::job_t head_job
);

  localparam int unsigned PtrBits = $clog2(mbp_pkg::QueueDepth);

  mbp_pkg::job_t          mem [mbp_pkg::QueueDepth];
  logic [PtrBits-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrBits-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PtrBits:0]       count_r, count_nxt;

  assign full      = (count_r == (PtrBits+1)'(mbp_pkg::QueueDepth));
  assign not_empty = (count_r != '0);
  assign head_job  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PtrBits'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PtrBits'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hdl/mbp_back.sv @@
// ----------------------------------------------------------------------------
// mbp_back: byte emitter
// Takes jobs from the queue and sends their bytes one per cycle, as out_ready
// allows, through a registered output stage, marking each job's last byte.
// ----------------------------------------------------------------------------
module mbp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  mbp_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [3:0]    out_vbits,
  output logic          out_last
);

  logic [mbp_pkg::ValueBits-1:0] word_r, word_nxt;
  logic [3:0]                    vb_r, vb_nxt;
  logic [mbp_pkg::NbBits-1:0]    cnt_r, cnt_nxt;
  logic                          ovalid_r, ovalid_nxt;
  logic [7:0]                    obyte_r, obyte_nxt;
  logic [3:0]                    ovb_r, ovb_nxt;
  logic                          olast_r, olast_nxt;
  logic                          slot_free;
  logic                          emit;
  logic [1:0]                    idx;

  always_comb begin
    slot_free = !ovalid_r || out_ready;
    emit      = (cnt_r != '0) && slot_free;
    pop       = q_not_empty && ((cnt_r == '0) || (cnt_r == mbp_pkg::NbBits'(1) && emit));
    idx       = 2'(cnt_r - 1'b1);

    word_nxt = pop ? q_job.word       : word_r;
    vb_nxt   = pop ? q_job.valid_bits : vb_r;
    if (pop) begin
      cnt_nxt = q_job.nbytes;
    end else if (emit) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end

    obyte_nxt = obyte_r;
    ovb_nxt   = ovb_r;
    olast_nxt = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = 8'(word_r >> {idx, 3'b000});
      ovb_nxt    = vb_r;
      olast_nxt  = (cnt_r == mbp_pkg::NbBits'(1));
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    vb_r    <= vb_nxt;
    obyte_r <= obyte_nxt;
    ovb_r   <= ovb_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_vbits = ovb_r;
  assign out_last  = olast_r;

endmodule

@@ hdl/msb_first_bit_packer.sv @@
// ----------------------------------------------------------------------------
// msb_first_bit_packer: MSB-first variable-length code packer
// Packs codes of 1 to 32 bits into a byte stream, first bit at the top.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel is an append (in_tuser low) carrying
// a code in the low bit_count bits of data_value, or a flush (in_tuser high).
// An append merges the code behind the bits already pending and produces one
// result per completed byte, zero to four of them. A flush sends the pending
// partial byte, padded with zeros at the low end, with its count of valid
// bits; it leaves the pending bits in place. Requests that complete no byte,
// and flushes with nothing pending, give no result. out_tlast marks the last
// byte produced by each request. A bit_count above the smaller of
// MAX_CODE_BITS and 32 is clipped to it; a count of zero appends nothing.
// Path: queue entry, then the emitter's job registers, then its output
// register. Throughput: the output sends one byte per cycle while out_tready
// allows, and a request occupies the emitter for each byte it makes (up to
// four). The next job loads in the cycle of the previous job's last byte;
// only a job that finds the emitter idle must load first. A two-entry job
// queue lets requests be taken while earlier bytes are still leaving. Reset
// clears the pending byte and all queued work. When the receiver stalls, the
// output register holds its byte, the queue fills and then in_tready drops.
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_value [31:0], bit_count [37:32], zeros
  input  logic        in_tuser,   // kind: 0 append, 1 flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte [7:0], valid_bits [11:8], zeros
  output logic        out_tlast
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  mbp_pkg::job_t push_job;
  mbp_pkg::job_t head_job;
  logic [7:0]    out_byte;
  logic [3:0]    out_vbits;

  // Front end: accumulates code bits and turns each request into a job.
  mbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_kind  (in_tuser),
    .req_value (in_tdata[31:0]),
    .req_count (in_tdata[37:32]),
    .q_full    (q_full),
    .req_ready (in_tready),
    .push      (push),
    .push_job  (push_job)
  );

  // Job queue between the two halves.
  mbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back end: sends the bytes of each job, one per cycle while out_tready allows.
  mbp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_byte),
    .out_vbits   (out_vbits),
    .out_last    (out_tlast)
  );

  assign out_tdata = {4'b0000, out_vbits, out_byte};

endmodule

@@ tb/sv/msb_first_bit_packer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_test: self-checking bench for the MSB-first bit packer
// Sends append and flush requests into the stream input. A behavioral packer
// in the bench predicts every byte, and each byte taken at the output is
// compared with the oldest prediction. Both sides idle at random. The sink
// also holds off once for a long stretch so that the internal job queue
// fills up and the input stalls.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_test;

  // The packer is built with its default code limit. Counts above the
  // smaller of this and the value width are clipped.
  localparam int unsigned CodeLimit  = 32;
  localparam int unsigned ClipBits   = (CodeLimit < mbp_pkg::ValueBits) ?
                                       CodeLimit : mbp_pkg::ValueBits;
  localparam int          RandomReqs = 158;
  localparam int          MaxIdle    = 10;
  localparam int          HoldOffLen = 80;   // long sink stall, in cycles
  localparam int          HoldOffAt  = 40;   // bytes taken before the long stall
  localparam int          DrainWait  = 20;   // cycles of quiet after the last byte
  localparam int          NumRows    = 22;

  // One predicted output byte.
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] vb;
    logic       last;
  } packed_byte_t;

  // One row of the directed table. When typed is set, the row gives its
  // result directly: either no byte at all, or a single byte (with tlast).
  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic [5:0]  count;
    logic        typed;
    logic        has_byte;
    logic [7:0]  exp_data;
    logic [3:0]  exp_vb;
  } step_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;    // data_value [31:0], bit_count [37:32], zeros
  logic        in_tuser   = 1'b0;  // kind: 0 append, 1 flush
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // out_byte [7:0], valid_bits [11:8], zeros
  logic        out_tlast;

  // Bench-side copy of the packer state.
  logic [7:0]  pend_bits = 8'h00;  // filled bits sit at the top
  int          pend_free = 8;      // empty low bits of pend_bits, 1..8

  packed_byte_t byte_queue[$];     // predicted bytes, oldest first
  int           error_count = 0;
  int           bytes_taken = 0;
  logic         no_idle     = 1'b0;  // both sides run without gaps
  logic         hold_off    = 1'b0;  // sink is in its long stall
  logic         stall_done  = 1'b0;

  msb_first_bit_packer #(
    .MAX_CODE_BITS(CodeLimit)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // The directed table walks through the corners: empty flush right after
  // reset, a zero count, a whole byte, a repeated flush that must give the
  // same partial byte again, clipped counts, high value bits that must be
  // ignored, and full 32-bit codes behind pending bits (four bytes).
  step_row_t dir_rows [NumRows] = '{
    '{mbp_pkg::KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b1, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h0000_00A5, 6'd8,  1'b1, 1'b1, 8'hA5, 4'd8},
    '{mbp_pkg::KIND_APPEND, 32'h0000_0001, 6'd1,  1'b1, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b1, 1'b1, 8'h80, 4'd1},
    '{mbp_pkg::KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b1, 1'b1, 8'h80, 4'd1},
    '{mbp_pkg::KIND_APPEND, 32'h0000_007F, 6'd7,  1'b1, 1'b1, 8'hFF, 4'd8},
    '{mbp_pkg::KIND_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h0000_0005, 6'd3,  1'b1, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b1, 1'b1, 8'hA0, 4'd3},
    '{mbp_pkg::KIND_APPEND, 32'h0000_0000, 6'd32, 1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h1234_5678, 6'd63, 1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'hDEAD_BEEF, 6'd33, 1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h7FFF_FFFF, 6'd31, 1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'hFFFF_FFE0, 6'd5,  1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_FLUSH,  32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h0000_0000, 6'd7,  1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h0000_0001, 6'd1,  1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'hA5A5_C3C3, 6'd16, 1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h0000_0003, 6'd2,  1'b0, 1'b0, 8'h00, 4'd0},
    '{mbp_pkg::KIND_APPEND, 32'h8000_0001, 6'd32, 1'b0, 1'b0, 8'h00, 4'd0}
  };

  // Behavioral packer. It returns the bytes one request produces and moves
  // the bench copy of the pending byte forward. The accumulator is wide
  // enough for seven pending bits in front of a full 32-bit code.
  function automatic int pack_request(input logic kind, input logic [31:0] value,
                                      input logic [5:0] count,
                                      output packed_byte_t [3:0] made);
    int          filled;
    int          cnt;
    int          nbits;
    int          n;
    logic [39:0] acc;
    logic [39:0] mask;
    made   = '0;
    n      = 0;
    filled = 8 - pend_free;
    if (kind == mbp_pkg::KIND_FLUSH) begin
      // A flush only reports the partial byte; the pending bits stay.
      if (filled == 0) return 0;
      made[0] = '{data: pend_bits, vb: 4'(filled), last: 1'b1};
      return 1;
    end
    cnt = int'(count);
    if (cnt > int'(ClipBits)) cnt = int'(ClipBits);
    if (cnt == 0) return 0;
    mask  = (40'd1 << cnt) - 40'd1;
    acc   = ((40'(pend_bits) >> pend_free) << cnt) | (40'(value) & mask);
    nbits = filled + cnt;
    while (nbits >= 8) begin
      nbits   = nbits - 8;
      made[n] = '{data: 8'(acc >> nbits), vb: 4'd8, last: 1'b0};
      n++;
    end
    if (n > 0) made[n-1].last = 1'b1;
    acc       = acc & ((40'd1 << nbits) - 40'd1);
    pend_bits = 8'(acc << (8 - nbits));
    pend_free = 8 - nbits;
    return n;
  endfunction

  // Offers one request after a random gap and returns at the edge where it
  // is taken. During the long sink stall the source keeps offering without
  // gaps so that the packer backs up into its input.
  task automatic offer_request(input logic kind, input logic [31:0] value,
                               input logic [5:0] count);
    int gap;
    gap = (no_idle || hold_off) ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, count, value};
    do @(posedge clk); while (!in_tready);
  endtask

  // Sends one request and queues what it should produce. The prediction is
  // made at the edge of acceptance, well before the bytes can come out.
  task automatic run_request(input logic kind, input logic [31:0] value,
                             input logic [5:0] count);
    packed_byte_t [3:0] made;
    int                 n;
    offer_request(kind, value, count);
    n = pack_request(kind, value, count, made);
    for (int i = 0; i < n; i++) byte_queue.insert(byte_queue.size(), made[i]);
  endtask

  // Stimulus: reset, the directed table, then the random part.
  initial begin : source
    packed_byte_t [3:0] scratch;
    packed_byte_t       typed_byte;
    int                 pick;
    logic               kind;
    logic [31:0]        value;
    logic [5:0]         count;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Typed rows take their expectation from the table. The predictor still
    // runs on them so that its pending byte stays in step with the packer.
    for (int r = 0; r < NumRows; r++) begin
      if (dir_rows[r].typed) begin
        offer_request(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].count);
        void'(pack_request(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].count,
                           scratch));
        if (dir_rows[r].has_byte) begin
          typed_byte = '{data: dir_rows[r].exp_data, vb: dir_rows[r].exp_vb,
                         last: 1'b1};
          byte_queue.insert(byte_queue.size(), typed_byte);
        end
      end else begin
        run_request(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].count);
      end
    end

    // Random part. Most requests are ordinary appends of 1 to 32 bits; the
    // rest are flushes, zero counts and counts that must be clipped. One
    // stretch in the middle runs with no idling on either side.
    for (int i = 0; i < RandomReqs; i++) begin
      no_idle <= (i >= 70 && i < 100);
      value = $urandom;
      pick  = $urandom_range(0, 99);
      kind  = mbp_pkg::KIND_APPEND;
      if (pick < 14) begin
        kind  = mbp_pkg::KIND_FLUSH;
        count = 6'($urandom_range(0, 63));
      end else if (pick < 19) begin
        count = 6'd0;
      end else if (pick < 27) begin
        count = 6'($urandom_range(ClipBits + 1, 63));
      end else if (pick < 35) begin
        count = 6'd8;
      end else begin
        count = 6'($urandom_range(1, ClipBits));
      end
      run_request(kind, value, count);
    end
    in_tvalid <= 1'b0;

    // Drain: every predicted byte has to arrive, then a quiet wait gives any
    // stray byte a chance to show up.
    while (byte_queue.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Sink: holds tready low for a random gap before each byte.
  // Once, after enough bytes have gone by, it stalls for a long stretch.
  initial begin : sink
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxIdle);
      if (!stall_done && bytes_taken >= HoldOffAt) begin
        stall      = HoldOffLen;
        stall_done = 1'b1;
        hold_off   = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      hold_off   = 1'b0;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Checks each byte taken at the output against the oldest prediction.
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_taken <= bytes_taken + 1;
      if (byte_queue.size() == 0) begin
        $error("unexpected byte: out_byte %02h valid_bits %0d is_last %0b",
               out_tdata[7:0], out_tdata[11:8], out_tlast);
        error_count++;
      end else begin
        want = byte_queue.pop_front();
        if (out_tdata[7:0] !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[11:8] !== want.vb) begin
          $error("valid_bits: expected %0d, got %0d", want.vb, out_tdata[11:8]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
